### rtl/aes_pkg.sv
// AES-128 package: S-box table, byte/word helpers and shared types.
// Used by every module of the aes128_block_encrypt block.
package aes_pkg;

	localparam int unsigned BLOCK_W = 128;
	localparam int unsigned HALF_W  = 64;
	localparam logic [7:0] GF_POLY_LOW  = 8'h1b;
	localparam logic [7:0] TOP_BIT      = 8'h80;

	// configuration register indexes
	localparam logic [0:0] REG_KEY_HIGH = 1'b0;
	localparam logic [0:0] REG_KEY_LOW  = 1'b1;

	typedef logic [BLOCK_W-1:0] block_t;

	// key-schedule control built in the top level to start the key chain
	typedef struct packed {
		logic        load;   // start a new expansion
		logic [127:0] key;   // cipher key, byte 0 in bits 127:120
	} key_ctl_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ ((a & TOP_BIT) != 8'h00 ? GF_POLY_LOW : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	// byte i of a block sits at bits 127-8i .. 120-8i
	function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
		return b[BLOCK_W-1-8*i -: 8];
	endfunction

	function automatic block_t sub_shift(input block_t s);
		block_t t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[BLOCK_W-1-8*(4*c+r) -: 8] = sbox(get_byte(s, 4*((c+r)%4)+r));
		return t;
	endfunction

	function automatic block_t mix_columns(input block_t s);
		block_t t;
		logic [7:0] a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4*c);
			a1 = get_byte(s, 4*c+1);
			a2 = get_byte(s, 4*c+2);
			a3 = get_byte(s, 4*c+3);
			all = a0 ^ a1 ^ a2 ^ a3;
			t[BLOCK_W-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			t[BLOCK_W-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			t[BLOCK_W-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[BLOCK_W-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

endpackage

### rtl/aes_key_cell.sv
// One key-schedule cell: derives the next round key from the previous one.
// Depends on aes_pkg.
module aes_key_cell import aes_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load_in,
	input  logic [127:0] key_in,
	input  logic [7:0]   rcon_in,
	output logic         load_out,
	output logic [127:0] key_out,
	output logic [7:0]   rcon_out
);
	logic [31:0] w0, w1, w2, w3, t;

	always_comb begin
		t  = sub_word({key_in[23:0], key_in[31:24]}) ^ {rcon_in, 24'h0};
		w0 = key_in[127:96] ^ t;
		w1 = key_in[95:64] ^ w0;
		w2 = key_in[63:32] ^ w1;
		w3 = key_in[31:0] ^ w2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_out <= 1'b0;
		end else begin
			load_out <= load_in;
		end
	end

	// key held only on a load so later cells keep their round key
	always_ff @(posedge clk) begin
		if (load_in) begin
			key_out  <= {w0, w1, w2, w3};
			rcon_out <= xtime(rcon_in);
		end
	end
endmodule

### rtl/aes_round_cell.sv
// One cipher round cell: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// Depends on aes_pkg.
module aes_round_cell import aes_pkg::*; #(
	parameter bit LAST = 1'b0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   vld_in,
	input  block_t state_in,
	input  block_t rkey,
	output logic   vld_out,
	output block_t state_out
);
	block_t ss, mx;

	always_comb begin
		ss = sub_shift(state_in);
		mx = LAST ? ss : mix_columns(ss);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			state_out <= mx ^ rkey;
		end
	end
endmodule

### rtl/aes128_block_encrypt.sv
// AES-128 encryption top level: key registers, key-schedule chain, round chain.
// Depends on aes_pkg, aes_key_cell, aes_round_cell.
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 writes
//    key_high, index 1 writes key_low; other indexes are dropped. cfg_ready is
//    always high. Each key write restarts the key schedule, which walks down a
//    chain of ten key cells, one round key per cycle: let the new round keys
//    reach the last key cell before sending a request.
//  - Input channel (in_valid/in_stall, plain_high, plain_low): one request per
//    cycle while in_stall is low.
//  - Output channel (out_valid/out_stall, cipher_high, cipher_low).
//  - The accepting edge loads the initial key add into a register, then ten
//    round cells follow, one register each.
//    Throughput: one block per cycle while the round chain is not frozen.
//  - When the receiver stalls while the last cell holds a result, the whole
//    round chain freezes and in_stall goes high at once; nothing is lost.
//  - Reset clears all valid flags and the key registers; round keys are
//    undefined until the first key write.
module aes128_block_encrypt import aes_pkg::*; #(
	parameter int ROUND_KEY_COUNT = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] plain_high,
	input  logic [63:0] plain_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low
);
	localparam int NR = ROUND_KEY_COUNT - 1;

	logic [63:0] key_high_q, key_low_q;
	logic        cfg_we;
	key_ctl_t    kctl;

	// round key r comes out of key cell r (cell 0 is the raw key)
	logic [127:0] rk   [ROUND_KEY_COUNT];
	logic [7:0]   rc   [ROUND_KEY_COUNT];
	logic         ld   [ROUND_KEY_COUNT];
	logic         kload_q;
	logic [127:0] key0_q;

	block_t st [ROUND_KEY_COUNT];
	logic   vl [ROUND_KEY_COUNT];
	logic   en;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			kload_q    <= 1'b0;
		end else begin
			kload_q <= cfg_we;
			if (cfg_we && cfg_index == REG_KEY_HIGH) key_high_q <= cfg_data;
			if (cfg_we && cfg_index == REG_KEY_LOW)  key_low_q  <= cfg_data;
		end
	end

	assign kctl.load = kload_q;
	assign kctl.key  = {key_high_q, key_low_q};

	// round key 0 is the key itself, captured after the register update
	always_ff @(posedge clk) begin
		if (kctl.load) key0_q <= kctl.key;
	end

	assign rk[0] = key0_q;
	assign rc[0] = 8'h01;
	logic ld0_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ld0_q <= 1'b0;
		else         ld0_q <= kctl.load;
	end
	assign ld[0] = ld0_q;

	for (genvar k = 1; k < ROUND_KEY_COUNT; k++) begin : g_key
		aes_key_cell u_key (
			.clk(clk), .arst_n(arst_n),
			.load_in(ld[k-1]), .key_in(rk[k-1]), .rcon_in(rc[k-1]),
			.load_out(ld[k]), .key_out(rk[k]), .rcon_out(rc[k])
		);
	end

	// chain advances unless a finished result is held
	assign en       = !(vl[NR] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vl[0] <= 1'b0;
		else if (en) vl[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) st[0] <= {plain_high, plain_low} ^ rk[0];
	end

	for (genvar r = 1; r < ROUND_KEY_COUNT; r++) begin : g_round
		aes_round_cell #(.LAST(r == NR)) u_round (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vl[r-1]), .state_in(st[r-1]), .rkey(rk[r]),
			.vld_out(vl[r]), .state_out(st[r])
		);
	end

	assign out_valid   = vl[NR];
	assign cipher_high = st[NR][127:64];
	assign cipher_low  = st[NR][63:0];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cipher_high) && $stable(cipher_low))
		else $error("result changed under stall");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall mismatch");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall && !vl[NR-1] |=> !out_valid)
		else $error("result appeared from empty stage");
endmodule
